>>> rtl/ffrp_pkg.sv
// ----------------------------------------------------------------------------
// ffrp_pkg: shared types and constants for the first-fit row packer
// Row count, time width and the token that travels down the cell chain.
// ----------------------------------------------------------------------------
package ffrp_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int TIME_BITS = 48;
    localparam int TAG_BITS  = 16;
    localparam int ROW_BITS  = 6;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [TAG_BITS-1:0]  tag_t;
    typedef logic [ROW_BITS-1:0]  row_t;

    // Request in flight through the chain
    typedef struct packed {
        logic  valid;     // slot holds a request
        logic  clear;     // first of batch: empty each row it passes
        logic  present;   // 0 = null event, no placement, no result
        logic  placed;    // some earlier cell already took it
        tag_t  tag;
        time_t start;
        time_t end_time;  // saturated start + duration
        row_t  row;
    } token_t;

endpackage

>>> rtl/ffrp_if.sv
// ----------------------------------------------------------------------------
// ffrp_if: request and result channels of the row packer
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface ffrp_item_if import ffrp_pkg::*;;
    logic  valid;
    logic  ready;
    logic  first_of_batch;
    logic  is_present;
    tag_t  event_tag;
    time_t start_time;
    time_t duration;

    modport source (output valid, first_of_batch, is_present, event_tag,
                    start_time, duration, input ready);
    modport sink   (input valid, first_of_batch, is_present, event_tag,
                    start_time, duration, output ready);
endinterface

interface ffrp_result_if import ffrp_pkg::*;;
    logic valid;
    logic ready;
    tag_t tag_out;
    row_t row_index;
    logic overflow;

    modport source (output valid, tag_out, row_index, overflow, input ready);
    modport sink   (input valid, tag_out, row_index, overflow, output ready);
endinterface

>>> rtl/first_fit_interval_row_packer_core.sv
// ----------------------------------------------------------------------------
// first_fit_interval_row_packer_core: first-fit interval row packer
// Systolic chain of MAX_ROWS cells; each request walks the rows in order.
// ----------------------------------------------------------------------------
// Pipeline: one entry stage for the saturating end-time add, then a register
//   in each row cell in chain order, then one output register.
// Throughput: one request per cycle; the chain stalls as a whole only while
//   the output register holds a result that is not taken.
// Reset: rst_n (async, active low) empties every row and the chain.
module first_fit_interval_row_packer_core import ffrp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ffrp_item_if.sink     item,
    ffrp_result_if.source result
);

    // Whole pipeline moves together; it holds only while a result waits.
    logic advance;

    // Entry stage: saturating end time, request becomes a token
    token_t               entry_reg, entry_next;
    logic [TIME_BITS:0]   sum_wide;

    // Chain taps: tap[i] feeds cell i, tap[MAX_ROWS] leaves the last cell
    token_t               tap [MAX_ROWS+1];

    // Output register
    logic                 out_valid_reg, out_valid_next;
    tag_t                 out_tag_reg;
    row_t                 out_row_reg;
    logic                 out_over_reg;
    token_t               last_tok;

    assign advance    = !out_valid_reg || result.ready;
    assign item.ready = advance;

    // start + duration, clamped to the top of the time range on carry out
    assign sum_wide = {1'b0, item.start_time} + {1'b0, item.duration};

    always_comb
    begin
        entry_next          = '0;
        entry_next.valid    = item.valid;
        entry_next.clear    = item.first_of_batch;
        entry_next.present  = item.is_present;
        entry_next.placed   = 1'b0;
        entry_next.tag      = item.event_tag;
        entry_next.start    = item.start_time;
        entry_next.end_time = sum_wide[TIME_BITS] ? '1 : sum_wide[TIME_BITS-1:0];
        entry_next.row      = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (advance)
        begin
            entry_reg <= entry_next;
        end
    end

    assign tap[0] = entry_reg;

    // Row cells. Rows in use are always a prefix of the chain, so the first
    // cell that is either free or unused is the first-fit choice; a later
    // request reaches each cell after the earlier one has moved on, so it always
    // sees that request's update.
    for (genvar i = 0; i < MAX_ROWS; i++)
    begin : g_cell
        ffrp_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .cell_id (row_t'(i)),
            .tok_in  (tap[i]),
            .tok_out (tap[i+1])
        );
    end

    assign last_tok = tap[MAX_ROWS];

    // Null events leave the chain without a result.
    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        if (advance)
        begin
            out_valid_next = last_tok.valid && last_tok.present;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Unplaced request means every row was busy: overflow, row reads zero.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_tag_reg  <= last_tok.tag;
            out_row_reg  <= last_tok.placed ? last_tok.row : '0;
            out_over_reg <= !last_tok.placed;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.tag_out   = out_tag_reg;
    assign result.row_index = out_row_reg;
    assign result.overflow  = out_over_reg;

endmodule

>>> rtl/ffrp_cell.sv
// ----------------------------------------------------------------------------
// ffrp_cell: one row of the packer
// Holds the row's end time and in-use flag; takes a passing request if free.
// ----------------------------------------------------------------------------
module ffrp_cell import ffrp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   advance,
    input  row_t   cell_id,
    input  token_t tok_in,
    output token_t tok_out
);

    token_t tok_reg, tok_next;
    time_t  end_reg, end_next;
    logic   used_reg, used_next;
    logic   used_eff;
    logic   hit;

    // a clearing request sees the row as empty
    assign used_eff = used_reg && !tok_in.clear;
    assign hit = tok_in.valid && tok_in.present && !tok_in.placed &&
                 (!used_eff || (end_reg <= tok_in.start));

    always_comb
    begin
        used_next = used_reg;
        end_next  = end_reg;
        tok_next  = tok_in;
        if (tok_in.valid)
        begin
            used_next = used_eff;
        end
        if (hit)
        begin
            used_next       = 1'b1;
            end_next        = tok_in.end_time;
            tok_next.placed = 1'b1;
            tok_next.row    = cell_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg  <= '0;
            used_reg <= 1'b0;
        end
        else if (advance)
        begin
            tok_reg  <= tok_next;
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            end_reg <= end_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for first_fit_interval_row_packer_core
// Drives interval requests over the valid/ready channel. A row-table model
// inside the bench predicts tag, row and overflow for each present request.
// Each result is compared, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb import ffrp_pkg::*;;

    localparam time_t TIME_TOP   = {TIME_BITS{1'b1}};
    localparam int    PIPE_DEPTH = MAX_ROWS + 2;   // accept to result valid

    typedef struct packed {
        tag_t tag;
        row_t row;
        logic overflow;
    } placement_t;

    logic clk;
    logic rst_n;

    ffrp_item_if   item_ch ();
    ffrp_result_if res_ch ();

    first_fit_interval_row_packer_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch)
    );

    // ------------------------------------------------------------------
    // Row table model: end tick per row plus count of open rows
    // ------------------------------------------------------------------
    time_t      row_end_tick [MAX_ROWS];
    int         rows_open;
    placement_t pending_placements [$];
    int         mismatch_count;

    // Traffic shaping knobs, percent of cycles
    int         send_idle_pct;
    int         recv_stall_pct;

    // Long receiver hold-off, counted down in its own process
    int         hold_left;
    int         hold_len;
    logic       hold_go;

    always #10 clk = ~clk;

    // Place one accepted request into the model table and queue its result
    task automatic place_interval(input logic fb, input logic pres, input tag_t tag,
                                  input time_t start, input time_t dur);
        logic [TIME_BITS:0] sum;
        time_t              stop;
        placement_t         p;
        int                 hit;
        begin
            if (fb)
            begin
                for (int r = 0; r < MAX_ROWS; r++)
                    row_end_tick[r] = '0;
                rows_open = 0;
            end
            if (pres)
            begin
                sum  = {1'b0, start} + {1'b0, dur};
                stop = sum[TIME_BITS] ? TIME_TOP : sum[TIME_BITS-1:0];
                hit  = -1;
                for (int r = 0; r < rows_open; r++)
                begin
                    if (hit < 0 && row_end_tick[r] <= start)
                        hit = r;
                end
                if (hit < 0 && rows_open < MAX_ROWS)
                begin
                    hit = rows_open;
                    rows_open++;
                end
                p.tag = tag;
                if (hit < 0)
                begin
                    // every row busy and no room left: dropped, row reads 0
                    p.row      = '0;
                    p.overflow = 1'b1;
                end
                else
                begin
                    row_end_tick[hit] = stop;
                    p.row      = row_t'(hit);
                    p.overflow = 1'b0;
                end
                pending_placements = {pending_placements, p};
            end
        end
    endtask

    // Offer one request; returns right after the edge where it is taken
    task automatic send_req(input logic fb, input logic pres, input tag_t tag,
                            input time_t start, input time_t dur);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                item_ch.valid <= 1'b0;
                @(posedge clk);
            end
            item_ch.valid          <= 1'b1;
            item_ch.first_of_batch <= fb;
            item_ch.is_present     <= pres;
            item_ch.event_tag      <= tag;
            item_ch.start_time     <= start;
            item_ch.duration       <= dur;
            @(posedge clk);
            while (!item_ch.ready)
                @(posedge clk);
            place_interval(fb, pres, tag, start, dur);
        end
    endtask

    function automatic time_t rand_time();
        return time_t'({$urandom(), $urandom()});
    endfunction

    // Input goes idle, then wait for every predicted result
    task automatic wait_drain();
        begin
            item_ch.valid <= 1'b0;
            while (pending_placements.size() != 0)
                @(posedge clk);
        end
    endtask

    // One batch: mostly sorted intervals (start up, equal starts by
    // duration down), sprinkled with null events and unsorted noise.
    task automatic send_batch(input int n);
        time_t cur;
        time_t dur;
        time_t prev_dur;
        int    inc;
        int    flavor;
        int    roll;
        begin
            flavor   = $urandom_range(0, 3);
            case (flavor)
                0:       cur = time_t'($urandom_range(0, 1000));
                1:       cur = rand_time();
                2:       cur = TIME_TOP - time_t'($urandom_range(0, 5000));
                default: cur = time_t'($urandom_range(0, 200));
            endcase
            prev_dur = TIME_TOP;
            for (int i = 0; i < n; i++)
            begin
                roll = $urandom_range(99);
                if (roll < 8)
                begin
                    send_req(i == 0, 1'b0, tag_t'($urandom), rand_time(), rand_time());
                end
                else if (roll < 16)
                begin
                    send_req($urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)),
                             tag_t'($urandom), rand_time(), rand_time());
                end
                else
                begin
                    inc = (i == 0) ? 0 : $urandom_range(0, 8);
                    if (cur > TIME_TOP - time_t'(inc))
                        cur = TIME_TOP;
                    else
                        cur = cur + time_t'(inc);
                    if ($urandom_range(0, 19) == 0)
                        dur = rand_time();
                    else if (flavor == 3)
                        dur = time_t'($urandom_range(0, 400));
                    else
                        dur = time_t'($urandom_range(0, 60));
                    if (i != 0 && inc == 0 && dur > prev_dur)
                        dur = prev_dur;
                    prev_dur = dur;
                    send_req(i == 0, 1'b1, tag_t'($urandom), cur, dur);
                end
            end
        end
    endtask

    task automatic send_random(input int n);
        int remaining;
        int b;
        begin
            remaining = n;
            while (remaining > 0)
            begin
                b = $urandom_range(1, 30);
                if (b > remaining)
                    b = remaining;
                send_batch(b);
                remaining -= b;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, saturation, null events with and without clear
    task automatic test_directed();
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            send_req(1'b1, 1'b1, 16'h0000, '0, '0);              // row 0, ends at 0
            send_req(1'b0, 1'b1, 16'hFFFF, '0, TIME_TOP);        // row 0 reused
            send_req(1'b0, 1'b1, 16'h5A5A, '0, 48'd5);           // new row
            send_req(1'b0, 1'b1, 16'hA5A5, 48'd5, 48'd10);       // row 1 free again
            send_req(1'b0, 1'b0, 16'h1234, 48'd7, 48'd1);        // null, no result
            send_req(1'b0, 1'b1, 16'h0F0F, 48'd15, 48'd0);       // row 1, zero length
            // end tick saturates at the top of the range
            send_req(1'b0, 1'b1, 16'hF0F0, TIME_TOP - 48'd3, 48'd100);
            send_req(1'b0, 1'b1, 16'h8001, TIME_TOP, TIME_TOP);
            send_req(1'b0, 1'b1, 16'h7FFE, TIME_TOP, 48'd1);
            // null event that still empties the table
            send_req(1'b1, 1'b0, 16'hFFFF, TIME_TOP, TIME_TOP);
            send_req(1'b0, 1'b1, 16'h0001, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
            send_req(1'b0, 1'b1, 16'h0002, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
            send_req(1'b1, 1'b1, 16'h0003, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
            send_req(1'b0, 1'b1, 16'h0004, 48'h8000_0000_0000, 48'h0000_0000_0001);
        end
    endtask

    // Fill all rows with overlapping intervals, then push past the end
    task automatic test_table_full();
        begin
            send_req(1'b1, 1'b1, 16'hC000, 48'd100, 48'd1000);
            for (int i = 1; i < MAX_ROWS + 3; i++)
                send_req(1'b0, 1'b1, tag_t'(16'hC000 + i), 48'd100, 48'd1000);
            send_req(1'b0, 1'b1, 16'hCFFF, 48'd1100, 48'd1);   // row 0 frees up
            send_req(1'b0, 1'b1, 16'hCFFE, 48'd1100, 48'd1);
        end
    endtask

    task automatic test_random_phase(input int n, input int idle, input int stall);
        begin
            send_idle_pct  = idle;
            recv_stall_pct = stall;
            send_random(n);
        end
    endtask

    // Receiver holds off long enough for the chain to fill and stall input
    task automatic test_backpressure();
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            hold_len = 4 * PIPE_DEPTH;
            item_ch.valid <= 1'b0;
            hold_go <= 1'b1;
            @(posedge clk);
            hold_go <= 1'b0;
            send_random(100);
        end
    endtask

    // Sender waits for an empty pipe midway
    task automatic test_drain_pause();
        begin
            send_idle_pct  = 30;
            recv_stall_pct = 30;
            send_random(25);
            wait_drain();
            send_random(25);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_go)
            hold_left <= hold_len;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
        res_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);

    // Result checker
    always @(posedge clk)
    begin
        placement_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_placements.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result tag=%h row=%0d ovf=%b", $realtime,
                             res_ch.tag_out, res_ch.row_index, res_ch.overflow);
            end
            else
            begin
                want = pending_placements.pop_front();
                if (res_ch.tag_out !== want.tag || res_ch.row_index !== want.row ||
                    res_ch.overflow !== want.overflow)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: mismatch exp tag=%h row=%0d ovf=%b, ",
                                  "got tag=%h row=%0d ovf=%b"},
                                 $realtime, want.tag, want.row, want.overflow,
                                 res_ch.tag_out, res_ch.row_index, res_ch.overflow);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        mismatch_count = 0;
        rows_open      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len       = 0;
        for (int r = 0; r < MAX_ROWS; r++)
            row_end_tick[r] = '0;
        item_ch.valid          <= 1'b0;
        item_ch.first_of_batch <= 1'b0;
        item_ch.is_present     <= 1'b0;
        item_ch.event_tag      <= '0;
        item_ch.start_time     <= '0;
        item_ch.duration       <= '0;
        hold_go                <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_table_full();
        test_random_phase(60, 0, 0);
        test_random_phase(60, 62, 0);
        test_random_phase(60, 0, 62);
        test_random_phase(60, 7, 7);
        test_backpressure();
        test_drain_pause();

        wait_drain();
        repeat (PIPE_DEPTH + 8) @(posedge clk);
        if (mismatch_count == 0 && pending_placements.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
rtl/ffrp_pkg.sv
rtl/ffrp_if.sv
rtl/ffrp_cell.sv
rtl/first_fit_interval_row_packer_core.sv
tb/tb.sv
